FILE: hdl/kmct_pkg.sv
`timescale 1ns / 1ps

package kmct_pkg;

    localparam int NUM_KEYS    = 64;
    localparam int TAG_WIDTH   = 32;
    localparam int KEY_W       = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int KEY_FIELD_W = 6;
    localparam int COST_W      = 32;
    localparam int TAG_FIELD_W = 32;
    localparam int LIMIT_W     = 8;
    // wide enough to compare a cell index against a threshold or a key field
    localparam int CMP_W       = KEY_W + LIMIT_W;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_QUERY  = 2'd1;
    localparam logic [1:0] ACT_POP    = 2'd2;

    typedef logic [TAG_WIDTH-1:0] tag_t;

    // search word handed from cell to cell
    typedef struct packed {
        logic               active;
        logic               pop;
        logic [LIMIT_W-1:0] limit;
        logic               found;
        logic [KEY_W-1:0]   key;
        logic [COST_W-1:0]  cost;
        tag_t               tag;
    } tok_t;

    // insert broadcast
    typedef struct packed {
        logic                   en;
        logic [KEY_FIELD_W-1:0] key;
        logic [COST_W-1:0]      cost;
        tag_t                   tag;
    } wr_t;

    // pop clear broadcast
    typedef struct packed {
        logic             en;
        logic [KEY_W-1:0] key;
    } clr_t;

    function automatic tag_t tag_from_field(input logic [TAG_FIELD_W-1:0] v);
        logic [TAG_WIDTH+TAG_FIELD_W-1:0] w;
        w = {{TAG_WIDTH{1'b0}}, v};
        return w[TAG_WIDTH-1:0];
    endfunction

    function automatic logic [TAG_FIELD_W-1:0] tag_to_field(input tag_t t);
        logic [TAG_WIDTH+TAG_FIELD_W-1:0] w;
        w = {{TAG_FIELD_W{1'b0}}, t};
        return w[TAG_FIELD_W-1:0];
    endfunction

endpackage

FILE: hdl/kmct_cell.sv
`timescale 1ns / 1ps

module kmct_cell
    import kmct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [KEY_W-1:0] idx,
    input  wr_t              wr,
    input  clr_t             clr,
    input  tok_t             tok_in,
    output tok_t             tok_out
);

    logic              valid_reg;
    logic              valid_next;
    logic [COST_W-1:0] cost_reg;
    logic [COST_W-1:0] cost_next;
    tag_t              tag_reg;
    tag_t              tag_next;
    tok_t              tok_reg;
    tok_t              tok_next;

    logic [CMP_W-1:0]  idx_ext;
    logic [CMP_W-1:0]  lim_ext;
    logic [CMP_W-1:0]  wkey_ext;
    logic              wr_hit;
    logic              cand;

    assign idx_ext  = {{LIMIT_W{1'b0}}, idx};
    assign lim_ext  = {{KEY_W{1'b0}}, tok_in.limit};
    assign wkey_ext = {{(CMP_W-KEY_FIELD_W){1'b0}}, wr.key};

    // keep the stored entry on equal cost
    assign wr_hit = wr.en && (wkey_ext == idx_ext) && (!valid_reg || (wr.cost < cost_reg));

    // strict compare: earlier cells win ties
    assign cand = tok_in.active && valid_reg && (idx_ext <= lim_ext)
                  && (!tok_in.found || (cost_reg < tok_in.cost));

    always_comb
    begin
        valid_next = valid_reg;
        cost_next  = cost_reg;
        tag_next   = tag_reg;
        if (wr_hit)
        begin
            valid_next = 1'b1;
            cost_next  = wr.cost;
            tag_next   = wr.tag;
        end
        else if (clr.en && (clr.key == idx))
        begin
            valid_next = 1'b0;
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        if (cand)
        begin
            tok_next.found = 1'b1;
            tok_next.key   = idx;
            tok_next.cost  = cost_reg;
            tok_next.tag   = tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cost_reg <= cost_next;
        tag_reg  <= tag_next;
    end

    assign tok_out = tok_reg;

endmodule

FILE: hdl/keyed_min_cost_table.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake             Fields
// in       sink       in_valid / in_stall   action, key, cost, payload_tag, threshold
// out      source     out_valid / out_stall found, min_key, min_cost, min_tag
//
// On an insert every cell checks the key at once and the next word is taken right after. A
// query or pop sends a search word down the row of NUM_KEYS cells, one cell per cycle,
// and its result passes from the last cell through a holding register into the output
// register; in_stall stays high meanwhile.
// A pop clears the chosen entry as the search word leaves the last cell.
// Reset empties the table at once. A stalled result is held in the output register
// and a second one waits in a holding register; inserts are taken only while none waits there.

module keyed_min_cost_table
    import kmct_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             action,
    input  logic [KEY_FIELD_W-1:0] key,
    input  logic [COST_W-1:0]      cost,
    input  logic [TAG_FIELD_W-1:0] payload_tag,
    input  logic [LIMIT_W-1:0]     threshold,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   found,
    output logic [KEY_FIELD_W-1:0] min_key,
    output logic [COST_W-1:0]      min_cost,
    output logic [TAG_FIELD_W-1:0] min_tag
);

    logic              busy_reg;
    logic              busy_next;
    logic              done_valid_reg;
    logic              done_valid_next;
    tok_t              done_reg;
    logic              out_valid_reg;
    logic              out_found_reg;
    logic [KEY_W-1:0]  out_key_reg;
    logic [COST_W-1:0] out_cost_reg;
    tag_t              out_tag_reg;

    logic              accept_in;
    logic              is_search;
    logic              out_free;
    logic              move_out;
    wr_t               wr;
    clr_t              clr;
    tok_t              tok_link [NUM_KEYS+1];
    logic [CMP_W-1:0]  key_ext;

    assign accept_in = in_valid && !in_stall;
    assign is_search = (action == ACT_QUERY) || (action == ACT_POP);
    assign in_stall  = busy_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign move_out  = done_valid_reg && out_free;

    assign wr.en   = accept_in && (action == ACT_INSERT);
    assign wr.key  = key;
    assign wr.cost = cost;
    assign wr.tag  = tag_from_field(payload_tag);

    // search word enters the first cell with nothing found yet
    always_comb
    begin
        tok_link[0].active = accept_in && is_search;
        tok_link[0].pop    = (action == ACT_POP);
        tok_link[0].limit  = threshold;
        tok_link[0].found  = 1'b0;
        tok_link[0].key    = '0;
        tok_link[0].cost   = '0;
        tok_link[0].tag    = '0;
    end

    genvar i;
    generate
        for (i = 0; i < NUM_KEYS; i++)
        begin : g_cell
            kmct_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .idx     (KEY_W'(i)),
                .wr      (wr),
                .clr     (clr),
                .tok_in  (tok_link[i]),
                .tok_out (tok_link[i+1])
            );
        end
    endgenerate

    assign clr.en  = tok_link[NUM_KEYS].active && tok_link[NUM_KEYS].pop
                     && tok_link[NUM_KEYS].found;
    assign clr.key = tok_link[NUM_KEYS].key;

    always_comb
    begin
        busy_next = busy_reg;
        if (accept_in && is_search)
        begin
            busy_next = 1'b1;
        end
        else if (move_out)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        done_valid_next = done_valid_reg;
        if (tok_link[NUM_KEYS].active)
        begin
            done_valid_next = 1'b1;
        end
        else if (move_out)
        begin
            done_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            done_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            done_valid_reg <= done_valid_next;
            if (out_free)
            begin
                out_valid_reg <= done_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_link[NUM_KEYS].active)
        begin
            done_reg <= tok_link[NUM_KEYS];
        end
        // hold the word while the sink stalls
        if (move_out)
        begin
            out_found_reg <= done_reg.found;
            out_key_reg   <= done_reg.key;
            out_cost_reg  <= done_reg.cost;
            out_tag_reg   <= done_reg.tag;
        end
    end

    assign key_ext   = {{LIMIT_W{1'b0}}, out_key_reg};
    assign out_valid = out_valid_reg;
    assign found     = out_found_reg;
    assign min_key   = key_ext[KEY_FIELD_W-1:0];
    assign min_cost  = out_cost_reg;
    assign min_tag   = tag_to_field(out_tag_reg);

    a_idle_no_search: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !tok_link[NUM_KEYS].active)
        else $error("search word in flight while idle");

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_valid_reg |-> busy_reg)
        else $error("pending result without an open search");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        tok_link[NUM_KEYS].active |-> !done_valid_reg)
        else $error("search result would overwrite a pending one");

    a_search_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_in && is_search) |=> busy_reg)
        else $error("search accepted without raising stall");

endmodule
